### rtl/bamr_pkg.sv
// ----------------------------------------------------------------------------
// bamr_pkg
// Shared types and constants of the bit-vector approximate matcher.
// ----------------------------------------------------------------------------
package bamr_pkg;

    // Request command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;

    // Field widths fixed by the interface
    localparam int SYMBOL_BITS = 8;
    localparam int POS_IN_BITS = 6;
    localparam int SCORE_BITS  = 6;
    localparam int RANGE_BITS  = 32;

    // Configuration port
    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;
    localparam int REG_IDX_BIT  = 2;
    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_DIST_LIMIT     = 1'b1;

    localparam logic [5:0] PATTERN_LENGTH_RST = 6'd1;
    localparam logic [5:0] DIST_LIMIT_RST     = 6'd0;

    typedef struct packed {
        logic [5:0] pattern_length;
        logic [5:0] dist_limit;
    } t_cfg;

endpackage

### rtl/bamr_ram.sv
// ----------------------------------------------------------------------------
// bamr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bamr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bamr_cfg.sv
// ----------------------------------------------------------------------------
// bamr_cfg
// APB register file holding pattern length and distance threshold.
// ----------------------------------------------------------------------------
module bamr_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bamr_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [bamr_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [bamr_pkg::PDATA_BITS-1:0]   prdata,
    output logic                              pready,
    output bamr_pkg::t_cfg                    o_cfg
);

    bamr_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_length <= bamr_pkg::PATTERN_LENGTH_RST;
            r_cfg.dist_limit     <= bamr_pkg::DIST_LIMIT_RST;
        end else if (wr_en) begin
            unique case (paddr[bamr_pkg::REG_IDX_BIT])
                bamr_pkg::REG_PATTERN_LENGTH: r_cfg.pattern_length <= pwdata[5:0];
                bamr_pkg::REG_DIST_LIMIT:     r_cfg.dist_limit     <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[bamr_pkg::REG_IDX_BIT])
            bamr_pkg::REG_PATTERN_LENGTH: prdata = bamr_pkg::PDATA_BITS'(r_cfg.pattern_length);
            bamr_pkg::REG_DIST_LIMIT:     prdata = bamr_pkg::PDATA_BITS'(r_cfg.dist_limit);
            default:                      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/bamr_myers_step.sv
// ----------------------------------------------------------------------------
// bamr_myers_step
// One column of the Myers bit-parallel edit distance recurrence.
// ----------------------------------------------------------------------------
module bamr_myers_step #(
    parameter int VECTOR_BITS = 64
) (
    input  logic [VECTOR_BITS-1:0]          i_eq,
    input  logic [VECTOR_BITS-1:0]          i_vp,
    input  logic [VECTOR_BITS-1:0]          i_vn,
    input  logic [$clog2(VECTOR_BITS)-1:0]  i_top_idx,
    input  logic [bamr_pkg::SCORE_BITS-1:0] i_score,
    output logic [VECTOR_BITS-1:0]          o_vp,
    output logic [VECTOR_BITS-1:0]          o_vn,
    output logic [bamr_pkg::SCORE_BITS-1:0] o_score
);

    logic [VECTOR_BITS-1:0]          d0;
    logic [VECTOR_BITS-1:0]          hp;
    logic [VECTOR_BITS-1:0]          hn;
    logic [VECTOR_BITS-1:0]          hp_sh;
    logic [VECTOR_BITS-1:0]          hn_sh;
    logic [bamr_pkg::SCORE_BITS-1:0] score_up;

    always_comb begin
        d0    = (((i_eq & i_vp) + i_vp) ^ i_vp) | i_eq | i_vn;
        hp    = i_vn | ~(d0 | i_vp);
        hn    = d0 & i_vp;
        hp_sh = hp << 1;
        hn_sh = hn << 1;
        o_vp  = hn_sh | ~(d0 | hp_sh);
        o_vn  = d0 & hp_sh;

        // saturate at both ends
        score_up = (hp[i_top_idx] && (i_score != '1)) ? i_score + 1'b1 : i_score;
        o_score  = (hn[i_top_idx] && (score_up != '0)) ? score_up - 1'b1 : score_up;
    end

endmodule

### rtl/bitvector_approx_match_ranges_top.sv
// ----------------------------------------------------------------------------
// bitvector_approx_match_ranges_top
// Streaming Myers bit-parallel matcher of a short query against a text.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result side is not
// stalled, and gives one result per request, in order. A request enters a
// stage register while the mask RAM is read at its symbol; when the stage
// advances, the bit vectors, score and match-run tracking are updated and
// the result lands in the output register. A load followed at once by a
// text or load request for the same symbol is served from a one-entry
// bypass, since the mask RAM read is registered. Clear empties the mask
// table at once through per-symbol valid bits, so no clearing pass follows
// reset. Configuration must be written over the APB port only while the
// block is idle; the block does not enforce this. A write applies to the
// next request.
// ----------------------------------------------------------------------------
module bitvector_approx_match_ranges_top #(
    parameter int VECTOR_BITS   = 64,
    parameter int ALPHABET_SIZE = 256,
    parameter int POSITION_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bamr_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [bamr_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [bamr_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready,

    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_cmd,
    input  logic [bamr_pkg::SYMBOL_BITS-1:0]    i_symbol,
    input  logic [bamr_pkg::POS_IN_BITS-1:0]    i_position,
    input  logic                                i_last_symbol,

    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bamr_pkg::SCORE_BITS-1:0]     o_score,
    output logic                                o_range_valid,
    output logic [bamr_pkg::RANGE_BITS-1:0]     o_range_end,
    output logic [bamr_pkg::RANGE_BITS-1:0]     o_range_earliest_start,
    output logic [bamr_pkg::SCORE_BITS-1:0]     o_range_edist
);

    localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int IW = $clog2(VECTOR_BITS);
    localparam int SB = bamr_pkg::SCORE_BITS;

    bamr_pkg::t_cfg cfg;

    // ------------------------------------------------------------------
    // Stage registers and handshake
    // ------------------------------------------------------------------
    logic                              r_s1_valid;
    logic [1:0]                        r_s1_cmd;
    logic [bamr_pkg::SYMBOL_BITS-1:0]  r_s1_symbol;
    logic [bamr_pkg::POS_IN_BITS-1:0]  r_s1_position;
    logic                              r_s1_last;

    logic                              r_out_valid;
    logic [SB-1:0]                     r_out_score;
    logic                              r_out_range_valid;
    logic [bamr_pkg::RANGE_BITS-1:0]   r_out_range_end;
    logic [bamr_pkg::RANGE_BITS-1:0]   r_out_range_start;
    logic [SB-1:0]                     r_out_range_edist;

    logic in_acc;
    logic out_take;
    logic s1_adv;

    assign out_take   = r_out_valid & ~i_out_stall;
    assign s1_adv     = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~s1_adv;
    assign in_acc     = i_in_valid & ~o_in_stall;

    // ------------------------------------------------------------------
    // Search state
    // ------------------------------------------------------------------
    logic [ALPHABET_SIZE-1:0]  r_entry_valid, n_entry_valid;
    logic [VECTOR_BITS-1:0]    r_vp, n_vp;
    logic [VECTOR_BITS-1:0]    r_vn, n_vn;
    logic [SB-1:0]             r_score, n_score;
    logic [POSITION_BITS-1:0]  r_count, n_count;
    logic [SB:0]               r_best, n_best;
    logic [POSITION_BITS-1:0]  r_best_end, n_best_end;
    logic                      r_in_run, n_in_run;

    // bypass of the write made at the edge a request was read
    logic                      r_fwd_valid;
    logic [AW-1:0]             r_fwd_addr;
    logic [VECTOR_BITS-1:0]    r_fwd_data;

    // ------------------------------------------------------------------
    // Configuration and effective query length
    // ------------------------------------------------------------------
    bamr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [5:0] eff_len;
    always_comb begin
        if (cfg.pattern_length == 6'd0) begin
            eff_len = 6'd1;
        end else if (cfg.pattern_length > 6'(VECTOR_BITS - 1)) begin
            eff_len = 6'(VECTOR_BITS - 1);
        end else begin
            eff_len = cfg.pattern_length;
        end
    end

    // ------------------------------------------------------------------
    // Mask table
    // ------------------------------------------------------------------
    logic                   sym_ok;
    logic                   pos_ok;
    logic [AW-1:0]          s1_addr;
    logic                   entry_hit;
    logic [VECTOR_BITS-1:0] ram_rdata;
    logic [VECTOR_BITS-1:0] mask;
    logic [VECTOR_BITS-1:0] pos_bit;
    logic [VECTOR_BITS-1:0] load_data;
    logic                   wr_en;

    assign sym_ok    = {1'b0, r_s1_symbol} < 9'(ALPHABET_SIZE);
    assign pos_ok    = {1'b0, r_s1_position} < 7'(VECTOR_BITS);
    assign s1_addr   = r_s1_symbol[AW-1:0];
    assign entry_hit = sym_ok && r_entry_valid[s1_addr];
    assign mask      = (r_fwd_valid && (r_fwd_addr == s1_addr)) ? r_fwd_data : ram_rdata;
    assign pos_bit   = VECTOR_BITS'(1) << r_s1_position;
    assign load_data = entry_hit ? (mask | pos_bit) : pos_bit;
    assign wr_en     = s1_adv && (r_s1_cmd == bamr_pkg::CMD_LOAD) && sym_ok && pos_ok;

    bamr_ram #(
        .WIDTH (VECTOR_BITS),
        .DEPTH (ALPHABET_SIZE)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (s1_addr),
        .i_wdata (load_data),
        .i_re    (in_acc),
        .i_raddr (i_symbol[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Bit-vector column update
    // ------------------------------------------------------------------
    logic [VECTOR_BITS-1:0] eq;
    logic [VECTOR_BITS-1:0] step_vp;
    logic [VECTOR_BITS-1:0] step_vn;
    logic [SB-1:0]          step_score;

    assign eq = entry_hit ? mask : '0;

    bamr_myers_step #(
        .VECTOR_BITS (VECTOR_BITS)
    ) u_step (
        .i_eq      (eq),
        .i_vp      (r_vp),
        .i_vn      (r_vn),
        .i_top_idx (IW'(eff_len - 6'd1)),
        .i_score   (r_score),
        .o_vp      (step_vp),
        .o_vn      (step_vn),
        .o_score   (step_score)
    );

    // ------------------------------------------------------------------
    // Match-run tracking for text requests
    // ------------------------------------------------------------------
    logic [POSITION_BITS-1:0] cnt_next;
    logic [SB:0]              best_run;
    logic [POSITION_BITS-1:0] best_end_run;
    logic                     in_run_run;
    logic                     rep;
    logic [POSITION_BITS-1:0] rep_end;
    logic [SB-1:0]            rep_edist;
    logic [SB:0]              span;
    logic [POSITION_BITS-1:0] span_w;
    logic [POSITION_BITS-1:0] rep_start;
    logic [SB:0]              best_rst;

    assign cnt_next = (&r_count) ? r_count : r_count + 1'b1;
    assign best_rst = {1'b0, cfg.dist_limit} + 1'b1;

    always_comb begin
        best_run     = r_best;
        best_end_run = r_best_end;
        in_run_run   = r_in_run;
        rep          = 1'b0;
        rep_end      = '0;
        rep_edist    = '0;
        if (cnt_next >= POSITION_BITS'(eff_len)) begin
            if ((step_score <= cfg.dist_limit) && ({1'b0, step_score} < r_best)) begin
                best_run     = {1'b0, step_score};
                best_end_run = cnt_next;
                in_run_run   = 1'b1;
            end else if (r_in_run && (step_score > cfg.dist_limit)) begin
                // run closed: report it and rearm the minimum
                rep        = 1'b1;
                in_run_run = 1'b0;
                rep_end    = r_best_end;
                rep_edist  = r_best[SB-1:0];
                best_run   = best_rst;
            end
        end
        if (r_s1_last && in_run_run) begin
            rep        = 1'b1;
            in_run_run = 1'b0;
            rep_end    = best_end_run;
            rep_edist  = best_run[SB-1:0];
        end
        // earliest start = end - min(len + dist, end)
        span      = {1'b0, eff_len} + {1'b0, rep_edist};
        span_w    = POSITION_BITS'(span);
        rep_start = rep ? (rep_end - ((span_w > rep_end) ? rep_end : span_w)) : '0;
    end

    // ------------------------------------------------------------------
    // Next state and result
    // ------------------------------------------------------------------
    logic                            n_out_range_valid;
    logic [SB-1:0]                   n_out_score;
    logic [bamr_pkg::RANGE_BITS-1:0] n_out_range_end;
    logic [bamr_pkg::RANGE_BITS-1:0] n_out_range_start;
    logic [SB-1:0]                   n_out_range_edist;
    logic                            restart;

    always_comb begin
        n_entry_valid     = r_entry_valid;
        n_vp              = r_vp;
        n_vn              = r_vn;
        n_score           = r_score;
        n_count           = r_count;
        n_best            = r_best;
        n_best_end        = r_best_end;
        n_in_run          = r_in_run;
        restart           = 1'b0;
        n_out_score       = r_score;
        n_out_range_valid = 1'b0;
        n_out_range_end   = '0;
        n_out_range_start = '0;
        n_out_range_edist = '0;

        case (r_s1_cmd)
            bamr_pkg::CMD_CLEAR: begin
                n_entry_valid = '0;
                restart       = 1'b1;
                // report the score of the fresh search
                n_out_score   = eff_len;
            end
            bamr_pkg::CMD_LOAD: begin
                if (sym_ok && pos_ok) begin
                    n_entry_valid[s1_addr] = 1'b1;
                end
            end
            bamr_pkg::CMD_TEXT: begin
                n_vp              = step_vp;
                n_vn              = step_vn;
                n_score           = step_score;
                n_count           = cnt_next;
                n_best            = best_run;
                n_best_end        = best_end_run;
                n_in_run          = in_run_run;
                restart           = r_s1_last;
                n_out_score       = step_score;
                n_out_range_valid = rep;
                n_out_range_end   = bamr_pkg::RANGE_BITS'(rep_end);
                n_out_range_start = bamr_pkg::RANGE_BITS'(rep_start);
                n_out_range_edist = rep_edist;
            end
            default: ;
        endcase

        if (restart) begin
            n_vp       = '1;
            n_vn       = '0;
            n_score    = eff_len;
            n_count    = '0;
            n_best     = best_rst;
            n_best_end = '0;
            n_in_run   = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_fwd_valid   <= 1'b0;
            r_entry_valid <= '0;
            r_vp          <= '1;
            r_vn          <= '0;
            r_score       <= bamr_pkg::PATTERN_LENGTH_RST;
            r_count       <= '0;
            r_best        <= {1'b0, bamr_pkg::DIST_LIMIT_RST} + 1'b1;
            r_best_end    <= '0;
            r_in_run      <= 1'b0;
        end else begin
            // stage register: load on accept, drop once advanced
            if (in_acc) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= wr_en;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            // output register
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_entry_valid <= n_entry_valid;
                r_vp          <= n_vp;
                r_vn          <= n_vn;
                r_score       <= n_score;
                r_count       <= n_count;
                r_best        <= n_best;
                r_best_end    <= n_best_end;
                r_in_run      <= n_in_run;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd      <= i_cmd;
            r_s1_symbol   <= i_symbol;
            r_s1_position <= i_position;
            r_s1_last     <= i_last_symbol;
            r_fwd_addr    <= s1_addr;
            r_fwd_data    <= load_data;
        end
        if (s1_adv) begin
            r_out_score       <= n_out_score;
            r_out_range_valid <= n_out_range_valid;
            r_out_range_end   <= n_out_range_end;
            r_out_range_start <= n_out_range_start;
            r_out_range_edist <= n_out_range_edist;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_score                = r_out_score;
    assign o_range_valid          = r_out_range_valid;
    assign o_range_end            = r_out_range_end;
    assign o_range_earliest_start = r_out_range_start;
    assign o_range_edist          = r_out_range_edist;

endmodule

### sim/bamr_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bamr_tb_pkg
// Result prediction and checking for the approximate matcher testbench.
// ----------------------------------------------------------------------------
package bamr_tb_pkg;
    import bamr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic                  range_valid;
        logic [RANGE_BITS-1:0] range_end;
        logic [RANGE_BITS-1:0] range_start;
        logic [SCORE_BITS-1:0] range_edist;
    } t_match_result;

    class match_tracker;
        logic [5:0]            pattern_length;
        logic [5:0]            dist_limit;
        logic [63:0]           mask_tbl [256];
        logic [255:0]          entry_valid;
        logic [63:0]           vpos;
        logic [63:0]           vneg;
        int unsigned           score;
        logic [RANGE_BITS-1:0] text_count;
        int unsigned           best_edist;
        logic [RANGE_BITS-1:0] best_end;
        bit                    in_run;
        t_match_result         owed [$];
        int unsigned           fails;

        function new();
            pattern_length = PATTERN_LENGTH_RST;
            dist_limit     = DIST_LIMIT_RST;
            entry_valid    = '0;
            foreach (mask_tbl[i]) mask_tbl[i] = '0;
            fails = 0;
            restart();
        endfunction

        // length zero behaves as one
        function int unsigned active_len();
            return (pattern_length == 0) ? 1 : pattern_length;
        endfunction

        function void restart();
            vpos       = '1;
            vneg       = '0;
            score      = active_len();
            text_count = '0;
            best_edist = dist_limit + 1;
            best_end   = '0;
            in_run     = 1'b0;
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == REG_PATTERN_LENGTH) pattern_length = data[5:0];
            else dist_limit = data[5:0];
        endfunction

        function int unsigned results_owed();
            return owed.size();
        endfunction

        function t_match_result close_run();
            t_match_result res;
            longint unsigned span;
            res  = '0;
            span = active_len() + best_edist;
            if (span > best_end) span = best_end;
            res.range_valid = 1'b1;
            res.range_end   = best_end;
            res.range_start = RANGE_BITS'(best_end - span);
            res.range_edist = SCORE_BITS'(best_edist);
            in_run = 1'b0;
            return res;
        endfunction

        function void note_request(logic [1:0] cmd, logic [7:0] sym, logic [5:0] pos,
                                   logic last);
            t_match_result res;
            logic [63:0]   eq, d0, hp, hn;
            int unsigned   m;
            res = '0;
            m   = active_len();
            case (cmd)
                CMD_CLEAR: begin
                    entry_valid = '0;
                    restart();
                end
                CMD_LOAD: begin
                    if (entry_valid[sym]) mask_tbl[sym] |= (64'd1 << pos);
                    else mask_tbl[sym] = 64'd1 << pos;
                    entry_valid[sym] = 1'b1;
                end
                CMD_TEXT: begin
                    eq = entry_valid[sym] ? mask_tbl[sym] : '0;
                    d0 = (((eq & vpos) + vpos) ^ vpos) | eq | vneg;
                    hp = vneg | ~(d0 | vpos);
                    hn = d0 & vpos;
                    if (hp[m-1] && score < 63) score++;
                    if (hn[m-1] && score > 0) score--;
                    hp   = hp << 1;
                    hn   = hn << 1;
                    vpos = hn | ~(d0 | hp);
                    vneg = d0 & hp;
                    if (text_count != '1) text_count++;
                    if (text_count >= m) begin
                        if (score <= dist_limit && score < best_edist) begin
                            best_edist = score;
                            best_end   = text_count;
                            in_run     = 1'b1;
                        end else if (in_run && score > dist_limit) begin
                            res = close_run();
                            best_edist = dist_limit + 1;
                        end
                    end
                    if (last && in_run) res = close_run();
                end
                default: ;
            endcase
            res.score = SCORE_BITS'(score);
            if (cmd == CMD_TEXT && last) restart();
            owed.insert(owed.size(), res);
        endfunction

        function void flag_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                fails++;
            end
        endfunction

        function void check_result(logic [5:0] r_score, logic r_valid, logic [31:0] r_end,
                                   logic [31:0] r_start, logic [5:0] r_edist);
            t_match_result want;
            if (owed.size() == 0) begin
                $display("%0t ns: result with no request outstanding, score %0d",
                         $time, r_score);
                fails++;
            end else begin
                want = owed.pop_front();
                flag_field("score", want.score, r_score);
                flag_field("range_valid", want.range_valid, r_valid);
                flag_field("range_end", want.range_end, r_end);
                flag_field("range_earliest_start", want.range_start, r_start);
                flag_field("range_edist", want.range_edist, r_edist);
            end
        endfunction
    endclass

endpackage

### sim/tb_bitvector_approx_match_ranges_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitvector_approx_match_ranges_top
// Randomized regression of the streaming bit-vector approximate matcher.
// ----------------------------------------------------------------------------
// Every request is mirrored into a software copy of the matcher that tracks
// the bit vectors, running score and match runs; each result that leaves
// the block is compared field by field with the oldest predicted one.
// After a directed warm-up, the run plays phases of query load plus text,
// where text is built mostly from mutated copies of the query so that match
// runs open and close often. Settings change between phases while idle,
// sometimes in the middle of an unfinished text. Both handshakes idle in
// random bursts; the tail of the run streams at full rate.
// ----------------------------------------------------------------------------
module tb_bitvector_approx_match_ranges_top;
    import bamr_pkg::*;
    import bamr_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CALM_TAIL    = 150;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [PADDR_BITS-1:0]  paddr         = '0;
    logic [PDATA_BITS-1:0]  pwdata        = '0;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_cmd         = CMD_CLEAR;
    logic [SYMBOL_BITS-1:0] i_symbol      = '0;
    logic [POS_IN_BITS-1:0] i_position    = '0;
    logic                   i_last_symbol = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic [SCORE_BITS-1:0]  o_score;
    logic                   o_range_valid;
    logic [RANGE_BITS-1:0]  o_range_end;
    logic [RANGE_BITS-1:0]  o_range_earliest_start;
    logic [SCORE_BITS-1:0]  o_range_edist;

    match_tracker model;
    int unsigned  items_sent = 0;
    int unsigned  calm_mark  = 32'hFFFF_FFFF;
    bit           calm       = 1'b0;
    int unsigned  gap_rate   = 0;
    int unsigned  stall_left = 0;
    int unsigned  mode_left  = 0;
    bit           stall_on   = 1'b0;

    // query and symbol set of the current text, kept across phases so that
    // a text left open can go on after a settings change
    logic [7:0]   alphabet [4];
    logic [7:0]   query [$];

    bitvector_approx_match_ranges_top DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_cmd                  (i_cmd),
        .i_symbol               (i_symbol),
        .i_position             (i_position),
        .i_last_symbol          (i_last_symbol),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_score                (o_score),
        .o_range_valid          (o_range_valid),
        .o_range_end            (o_range_end),
        .o_range_earliest_start (o_range_earliest_start),
        .o_range_edist          (o_range_edist)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side back-pressure: stall in random bursts while the stall mode
    // is on; flip the mode now and then to leave clean stretches.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_on  <= ($urandom_range(0, 2) != 0);
            mode_left <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (calm) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 15);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Check every result taken off the block; an unknown valid counts as one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid !== 1'b0 && i_out_stall == 1'b0)
            model.check_result(o_score, o_range_valid, o_range_end,
                               o_range_earliest_start, o_range_edist);
    end

    // Drop the request valid to leave an idle gap.
    task automatic idle_gap(int unsigned n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Present one request, hold it until accepted, then note it for prediction.
    task automatic send_request(logic [1:0] cmd, logic [7:0] sym, logic [5:0] pos,
                                logic last);
        if (!calm && gap_rate != 0 && $urandom_range(1, gap_rate) == 1)
            idle_gap($urandom_range(1, 16));
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_symbol      <= sym;
        i_position    <= pos;
        i_last_symbol <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        model.note_request(cmd, sym, pos, last);
        items_sent++;
        if (items_sent >= calm_mark) calm = 1'b1;
    endtask

    // Hold off new requests until every predicted result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (model.results_owed() != 0) @(negedge i_clk);
    endtask

    // Setup phase, then access phase; the register takes the data once
    // pready is seen high in the access phase.
    task automatic apb_write(logic idx, logic [31:0] data);
        logic [PADDR_BITS-1:0] addr;
        addr = '0;
        addr[REG_IDX_BIT] = idx;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        model.write_reg(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Query 00 FF 41 5A, length 4, one edit allowed: exact hit, run close on
    // a rising score, run close on the final symbol, loads past the query end,
    // the unused command, and a symbol that has no mask since the clear.
    task automatic directed_checks();
        send_request(CMD_LOAD, 8'h00, 6'd0, 1'b0);
        send_request(CMD_LOAD, 8'hFF, 6'd1, 1'b1);
        send_request(CMD_LOAD, 8'h41, 6'd2, 1'b0);
        send_request(CMD_LOAD, 8'h5A, 6'd3, 1'b0);
        send_request(CMD_LOAD, 8'hFF, 6'd63, 1'b0);
        send_request(CMD_UNUSED, 8'hFF, 6'd63, 1'b1);
        send_request(CMD_TEXT, 8'h80, 6'd0, 1'b0);
        send_request(CMD_TEXT, 8'h00, 6'd63, 1'b0);
        send_request(CMD_TEXT, 8'hFF, 6'd0, 1'b0);
        send_request(CMD_TEXT, 8'h41, 6'd0, 1'b0);
        send_request(CMD_TEXT, 8'h5A, 6'd0, 1'b0);
        send_request(CMD_TEXT, 8'h41, 6'd0, 1'b0);
        repeat (3) send_request(CMD_TEXT, 8'h80, 6'd0, 1'b0);
        send_request(CMD_TEXT, 8'h00, 6'd0, 1'b0);
        send_request(CMD_TEXT, 8'hFF, 6'd0, 1'b0);
        send_request(CMD_TEXT, 8'h41, 6'd0, 1'b0);
        send_request(CMD_TEXT, 8'h5A, 6'd0, 1'b1);
        send_request(CMD_TEXT, 8'h80, 6'd0, 1'b1);
        send_request(CMD_CLEAR, 8'hFF, 6'd63, 1'b1);
    endtask

    // One phase: settle, maybe change settings, maybe load a new query, then
    // stream a text built from mutated query copies with some noise mixed in.
    task automatic run_phase();
        logic [7:0]  texts [$];
        int unsigned qlen, pick, k;
        bit          fresh, open_end;

        wait_drained();
        case ($urandom_range(0, 2))
            0:       gap_rate = 0;
            1:       gap_rate = 3;
            default: gap_rate = 10;
        endcase

        // mostly short queries; the extremes now and then
        case ($urandom_range(0, 11))
            0:       qlen = 0;
            1:       qlen = 1;
            2:       qlen = 63;
            3, 4:    qlen = $urandom_range(1, 63);
            default: qlen = $urandom_range(2, 10);
        endcase
        if ($urandom_range(0, 3) != 0)
            apb_write(REG_PATTERN_LENGTH, {26'($urandom), 6'(qlen)});
        qlen = model.active_len();
        case ($urandom_range(0, 7))
            0:       pick = 0;
            1:       pick = 63;
            6, 7:    pick = $urandom_range(0, 63);
            default: pick = $urandom_range(0, qlen / 3 + 1);
        endcase
        if ($urandom_range(0, 3) != 0)
            apb_write(REG_DIST_LIMIT, {26'($urandom), 6'(pick)});

        fresh = (query.size() == 0) || ($urandom_range(0, 7) != 0);
        if (fresh) begin
            for (k = 0; k < 4; k++) alphabet[k] = 8'($urandom);
            send_request(CMD_CLEAR, 8'($urandom), 6'($urandom), 1'($urandom));
            query.delete();
            for (k = 0; k < qlen; k++)
                query.insert(query.size(), alphabet[$urandom_range(0, 3)]);
            foreach (query[qi]) send_request(CMD_LOAD, query[qi], 6'(qi), 1'($urandom));
            if (qlen < 63 && $urandom_range(0, 3) == 0)
                send_request(CMD_LOAD, alphabet[$urandom_range(0, 3)],
                             6'($urandom_range(qlen, 63)), 1'b0);
        end

        // substitute, drop or insert around each copied query symbol
        while (texts.size() < $urandom_range(12, 60)) begin
            if ($urandom_range(0, 2) == 0) begin
                foreach (query[qi]) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8) begin
                        texts.insert(texts.size(), alphabet[$urandom_range(0, 3)]);
                    end else if (pick >= 15) begin
                        if (pick >= 94)
                            texts.insert(texts.size(), alphabet[$urandom_range(0, 3)]);
                        texts.insert(texts.size(), query[qi]);
                    end
                end
            end else if ($urandom_range(0, 19) == 0) begin
                texts.insert(texts.size(), 8'($urandom));
            end else begin
                texts.insert(texts.size(), alphabet[$urandom_range(0, 3)]);
            end
        end

        // leave some texts open so the next settings change lands mid-text
        open_end = ($urandom_range(0, 5) == 0);
        foreach (texts[ti]) begin
            if ($urandom_range(0, 39) == 0)
                send_request(2'($urandom), 8'($urandom), 6'($urandom), 1'($urandom));
            send_request(CMD_TEXT, texts[ti], 6'($urandom),
                         (ti == texts.size() - 1) && !open_end);
        end
    endtask

    initial begin
        int unsigned rand_base;
        model = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apb_write(REG_PATTERN_LENGTH, 32'd4);
        apb_write(REG_DIST_LIMIT, 32'd1);

        // write every mask entry once so no later read finds it unwritten
        gap_rate = 4;
        for (int s = 0; s < 256; s++)
            send_request(CMD_LOAD, 8'(s), 6'($urandom), 1'($urandom));
        send_request(CMD_CLEAR, 8'($urandom), 6'($urandom), 1'b0);

        gap_rate = 0;
        directed_checks();

        rand_base = items_sent;
        calm_mark = rand_base + RANDOM_ITEMS - CALM_TAIL;
        while (items_sent < rand_base + RANDOM_ITEMS) run_phase();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (model.fails == 0) begin
            $display("bitvector_approx_match_ranges_top regression: pass");
        end else begin
            $display("bitvector_approx_match_ranges_top regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #10_000_000;
        $display("bitvector_approx_match_ranges_top regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/bamr_pkg.sv
rtl/bamr_ram.sv
rtl/bamr_cfg.sv
rtl/bamr_myers_step.sv
rtl/bitvector_approx_match_ranges_top.sv
sim/bamr_tb_pkg.sv
sim/tb_bitvector_approx_match_ranges_top.sv
